[hw/rtl/bphd_pkg.sv]
// Package for the bar peak-hold meter: level widths, shift constants and
// the per-tracker update function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bphd_pkg;

    localparam int unsigned LEVEL_W   = 16;
    localparam int unsigned MAG_W     = 8;
    localparam int unsigned FRAC_W    = 8;
    localparam int unsigned IDX_W     = 6;
    localparam int unsigned ROW_W     = 5;
    localparam int unsigned ROW_SHIFT = 11;
    localparam int unsigned SHIFT_W   = 4;
    localparam int unsigned STEP_W    = 5;
    localparam logic [SHIFT_W-1:0] DECAY_RESET = 4'd3;
    localparam logic [STEP_W-1:0]  BAR_EXTRA   = 5'd2;

    typedef logic [LEVEL_W-1:0] level_t;

    typedef struct packed {
        level_t peak;
        level_t bar;
    } entry_t;

    // Jump to the magnitude when it tops the integer part, else fall by
    // 2^shift and floor at zero.
    function automatic level_t track(input level_t lvl, input logic [MAG_W-1:0] mag,
                                     input logic [STEP_W-1:0] shift);
        logic [LEVEL_W:0] step;
        level_t           res;
        step = '0;
        res  = '0;
        if (mag > lvl[LEVEL_W-1:FRAC_W]) begin
            res = {mag, {FRAC_W{1'b0}}};
        end else if (shift < STEP_W'(LEVEL_W)) begin
            step = (LEVEL_W+1)'(1) << shift;
            if ({1'b0, lvl} > step) begin
                res = lvl - step[LEVEL_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bar_peak_hold_decay.sv]
// Bar peak-hold meter: one word in, one word out. Throughput one word
// per cycle unless m_ready stalls; the tracker memory read-modify-write
// is forwarded from the last write, so repeated bars need no interlock.
// Reset clears all entry valid bits (every tracker reads as zero) and sets
// decay_shift to 3; no clearing pass. Depends on bphd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bar_peak_hold_decay #(
    parameter int unsigned BAR_COUNT = 64
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              decay_shift_we,
    input  wire [bphd_pkg::SHIFT_W-1:0]      decay_shift_wdata,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire [bphd_pkg::IDX_W-1:0]        s_bar_index,
    input  wire [bphd_pkg::MAG_W-1:0]        s_magnitude,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [bphd_pkg::IDX_W-1:0]       m_out_bar_index,
    output logic [bphd_pkg::ROW_W-1:0]       m_bar_height,
    output logic [bphd_pkg::ROW_W-1:0]       m_peak_row
);

    localparam int unsigned ADDR_W = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
    localparam int unsigned EXT_W  = 9;

    bphd_pkg::entry_t mem [BAR_COUNT];
    logic [BAR_COUNT-1:0] ent_vld_reg;

    logic [bphd_pkg::SHIFT_W-1:0] decay_reg;

    logic [EXT_W-1:0]  idx_ext;
    logic              in_rng;
    logic [ADDR_W-1:0] rd_addr;
    logic              accept;
    logic              out_free;

    logic                        s1_vld_reg;
    logic                        s1_rng_reg;
    logic [ADDR_W-1:0]           s1_addr_reg;
    logic [bphd_pkg::IDX_W-1:0]  s1_idx_reg;
    logic [bphd_pkg::MAG_W-1:0]  s1_mag_reg;
    bphd_pkg::entry_t            rd_data_reg;
    logic                        rd_vld_reg;

    logic                        wb_vld_reg;
    logic [ADDR_W-1:0]           wb_addr_reg;
    bphd_pkg::entry_t            wb_data_reg;

    logic                        fwd_hit;
    bphd_pkg::entry_t            old_ent;
    bphd_pkg::entry_t            new_ent;
    logic                        mem_we;

    logic                        m_valid_reg;
    logic [bphd_pkg::IDX_W-1:0]  m_idx_reg;
    logic [bphd_pkg::ROW_W-1:0]  m_height_reg;
    logic [bphd_pkg::ROW_W-1:0]  m_peak_reg;

    assign idx_ext  = EXT_W'(s_bar_index);
    assign in_rng   = idx_ext < EXT_W'(BAR_COUNT);
    assign rd_addr  = idx_ext[ADDR_W-1:0];
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !s1_vld_reg || out_free;
    assign accept   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg <= bphd_pkg::DECAY_RESET;
        end else if (decay_shift_we) begin
            decay_reg <= decay_shift_wdata;
        end
    end

    // stage 1: memory read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (accept) begin
            s1_vld_reg <= 1'b1;
        end else if (out_free) begin
            s1_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_rng_reg  <= in_rng;
            s1_addr_reg <= rd_addr;
            s1_idx_reg  <= s_bar_index;
            s1_mag_reg  <= s_magnitude;
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= in_rng && ent_vld_reg[rd_addr];
        end
    end

    // stage 2: modify with forwarding, write back
    assign fwd_hit = wb_vld_reg && (wb_addr_reg == s1_addr_reg);

    always_comb begin
        if (fwd_hit) begin
            old_ent = wb_data_reg;
        end else if (rd_vld_reg) begin
            old_ent = rd_data_reg;
        end else begin
            old_ent = '0;
        end
        new_ent.peak = bphd_pkg::track(old_ent.peak, s1_mag_reg,
                                       bphd_pkg::STEP_W'(decay_reg));
        new_ent.bar  = bphd_pkg::track(old_ent.bar, s1_mag_reg,
                                       bphd_pkg::STEP_W'(decay_reg) + bphd_pkg::BAR_EXTRA);
    end

    assign mem_we = s1_vld_reg && s1_rng_reg && out_free;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[s1_addr_reg] <= new_ent;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ent_vld_reg <= '0;
            wb_vld_reg  <= 1'b0;
        end else if (mem_we) begin
            ent_vld_reg[s1_addr_reg] <= 1'b1;
            wb_vld_reg               <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wb_addr_reg <= s1_addr_reg;
            wb_data_reg <= new_ent;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && s1_vld_reg) begin
            m_idx_reg <= s1_idx_reg;
            if (s1_rng_reg) begin
                m_height_reg <= old_ent.bar[bphd_pkg::LEVEL_W-1:bphd_pkg::ROW_SHIFT];
                m_peak_reg   <= new_ent.peak[bphd_pkg::LEVEL_W-1:bphd_pkg::ROW_SHIFT];
            end else begin
                m_height_reg <= '0;
                m_peak_reg   <= '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_bar_index = m_idx_reg;
    assign m_bar_height    = m_height_reg;
    assign m_peak_row      = m_peak_reg;

    a_we_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> s1_vld_reg && s1_rng_reg)
        else $error("tracker write for an out-of-range bar");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_vld_reg)
        else $error("accepted word lost before stage 2");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s1_vld_reg |-> s_ready)
        else $error("input stalled with empty pipeline");

    a_jump: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we && (s1_mag_reg > old_ent.peak[bphd_pkg::LEVEL_W-1:bphd_pkg::FRAC_W])
        |-> new_ent.peak[bphd_pkg::LEVEL_W-1:bphd_pkg::FRAC_W] == s1_mag_reg)
        else $error("peak did not jump to magnitude");

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_vld_reg && !out_free |=> s1_vld_reg && $stable(s1_idx_reg))
        else $error("stage 2 word dropped under stall");

endmodule

`default_nettype wire

[sim/meter_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for bar_peak_hold_decay: keeps its own peak and bar levels per bar,
// predicts every result word and compares it with the output channel.
// Depends on bphd_pkg.

module meter_checker (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         decay_shift_we,
    input  wire [bphd_pkg::SHIFT_W-1:0] decay_shift_wdata,
    input  wire                         s_valid,
    input  wire                         s_ready,
    input  wire [bphd_pkg::IDX_W-1:0]   s_bar_index,
    input  wire [bphd_pkg::MAG_W-1:0]   s_magnitude,
    input  wire                         m_valid,
    input  wire                         m_ready,
    input  wire [bphd_pkg::IDX_W-1:0]   m_out_bar_index,
    input  wire [bphd_pkg::ROW_W-1:0]   m_bar_height,
    input  wire [bphd_pkg::ROW_W-1:0]   m_peak_row,
    output int                          mismatches,
    output int                          pending,
    output int                          compared
);

    localparam int BARS = 64;

    typedef struct packed {
        logic [bphd_pkg::IDX_W-1:0] bar;
        logic [bphd_pkg::ROW_W-1:0] height;
        logic [bphd_pkg::ROW_W-1:0] peak;
    } meter_word_t;

    bphd_pkg::level_t              peak_lvl [BARS];
    bphd_pkg::level_t              bar_lvl  [BARS];
    logic [bphd_pkg::SHIFT_W-1:0]  decay;
    meter_word_t                   rows_q [$];
    int                            fails   = 0;
    int                            checked = 0;

    function automatic bphd_pkg::level_t settle(input bphd_pkg::level_t lvl,
                                                input logic [bphd_pkg::MAG_W-1:0] mag,
                                                input int unsigned shift);
        int unsigned fall;
        if (mag > lvl[bphd_pkg::LEVEL_W-1:bphd_pkg::FRAC_W])
            return {mag, {bphd_pkg::FRAC_W{1'b0}}};
        if (shift >= bphd_pkg::LEVEL_W) return '0;
        fall = 32'd1 << shift;
        if (32'(lvl) > fall) return lvl - bphd_pkg::level_t'(fall);
        return '0;
    endfunction

    always @(posedge aclk) begin
        meter_word_t want;
        meter_word_t got;
        int unsigned b;
        if (!aresetn) begin
            for (int i = 0; i < BARS; i++) begin
                peak_lvl[i] = '0;
                bar_lvl[i]  = '0;
            end
            decay = bphd_pkg::DECAY_RESET;
            rows_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                b           = 32'(s_bar_index);
                want.bar    = s_bar_index;
                want.height = bphd_pkg::ROW_W'(bar_lvl[b] >> bphd_pkg::ROW_SHIFT);
                peak_lvl[b] = settle(peak_lvl[b], s_magnitude, 32'(decay));
                bar_lvl[b]  = settle(bar_lvl[b], s_magnitude, 32'(decay) + 32'd2);
                want.peak   = bphd_pkg::ROW_W'(peak_lvl[b] >> bphd_pkg::ROW_SHIFT);
                rows_q.push_back(want);
            end
            if (m_valid && m_ready) begin
                got = {m_out_bar_index, m_bar_height, m_peak_row};
                if (rows_q.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected word: bar %0d height %0d peak %0d",
                                 got.bar, got.height, got.peak);
                    fails++;
                end else begin
                    want = rows_q.pop_front();
                    checked++;
                    if (got !== want) begin
                        if (fails < 10)
                            $display({"mismatch: expected bar %0d height %0d peak %0d, ",
                                      "got bar %0d height %0d peak %0d"},
                                     want.bar, want.height, want.peak,
                                     got.bar, got.height, got.peak);
                        fails++;
                    end
                end
            end
            if (decay_shift_we) decay = decay_shift_wdata;
        end
        pending    <= rows_q.size();
        mismatches <= fails;
        compared   <= checked;
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Top of the bar_peak_hold_decay bench: clock, reset, stimulus, idling and verdict.
// Depends on bphd_pkg, bar_peak_hold_decay and meter_checker.

module tb;

    localparam int IDLE_LIMIT = 5000;
    localparam int PHASES     = 12;
    localparam int PHASE_LEN  = 155;

    logic                          aclk              = 1'b0;
    logic                          aresetn           = 1'b0;
    logic                          decay_shift_we    = 1'b0;
    logic [bphd_pkg::SHIFT_W-1:0]  decay_shift_wdata = '0;
    logic                          s_valid           = 1'b0;
    logic [bphd_pkg::IDX_W-1:0]    s_bar_index       = '0;
    logic [bphd_pkg::MAG_W-1:0]    s_magnitude       = '0;
    logic                          m_ready           = 1'b0;
    wire                           s_ready;
    wire                           m_valid;
    wire [bphd_pkg::IDX_W-1:0]     m_out_bar_index;
    wire [bphd_pkg::ROW_W-1:0]     m_bar_height;
    wire [bphd_pkg::ROW_W-1:0]     m_peak_row;

    int mismatches;
    int pending;
    int compared;
    int words_sent     = 0;
    int settings_used  = 0;
    int quiet_cycles   = 0;
    bit calm           = 1'b1;

    initial begin
        forever #5 aclk = ~aclk;
    end

    bar_peak_hold_decay #(
        .BAR_COUNT(64)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .decay_shift_we   (decay_shift_we),
        .decay_shift_wdata(decay_shift_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_bar_index      (s_bar_index),
        .s_magnitude      (s_magnitude),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_bar_index  (m_out_bar_index),
        .m_bar_height     (m_bar_height),
        .m_peak_row       (m_peak_row)
    );

    meter_checker i_meter_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .decay_shift_we   (decay_shift_we),
        .decay_shift_wdata(decay_shift_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_bar_index      (s_bar_index),
        .s_magnitude      (s_magnitude),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_out_bar_index  (m_out_bar_index),
        .m_bar_height     (m_bar_height),
        .m_peak_row       (m_peak_row),
        .mismatches       (mismatches),
        .pending          (pending),
        .compared         (compared)
    );

    function automatic int idle_draw();
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    task automatic send_word(input logic [bphd_pkg::IDX_W-1:0] idx,
                             input logic [bphd_pkg::MAG_W-1:0] mag);
        int gap;
        gap = idle_draw();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_bar_index <= idx;
        s_magnitude <= mag;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    // Hold the input until every result is out, then let the pipe settle.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_decay(input logic [bphd_pkg::SHIFT_W-1:0] v);
        drain();
        decay_shift_we    <= 1'b1;
        decay_shift_wdata <= v;
        @(posedge aclk);
        decay_shift_we    <= 1'b0;
        settings_used++;
    endtask

    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = idle_draw();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        int focus;
        int pick;
        int r;
        logic [bphd_pkg::IDX_W-1:0] idx;
        logic [bphd_pkg::MAG_W-1:0] mag;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset decay: jumps, equal integer part, floor, row boundaries
        send_word(6'd0, 8'd255);
        send_word(6'd0, 8'd255);
        send_word(6'd0, 8'd0);
        send_word(6'd63, 8'd0);
        send_word(6'd63, 8'd255);
        send_word(6'd63, 8'd254);
        send_word(6'd1, 8'd1);
        send_word(6'd1, 8'd0);
        send_word(6'd2, 8'd8);
        send_word(6'd2, 8'd7);
        send_word(6'd32, 8'd128);
        send_word(6'd31, 8'd127);
        calm = 1'b0;
        write_decay(4'd0);
        send_word(6'd0, 8'd0);
        send_word(6'd63, 8'd0);
        send_word(6'd0, 8'd255);
        // largest shift: bar step clears outright
        write_decay(4'd15);
        send_word(6'd0, 8'd0);
        send_word(6'd63, 8'd0);
        send_word(6'd5, 8'd200);
        send_word(6'd5, 8'd0);
        write_decay(4'd13);
        send_word(6'd5, 8'd0);
        send_word(6'd5, 8'd0);
        send_word(6'd3, 8'd255);
        send_word(6'd3, 8'd0);

        for (int p = 0; p < PHASES; p++) begin
            calm = (p % 3 == 1);
            write_decay(p == 0 ? 4'd8 : 4'($urandom_range(0, 15)));
            focus = $urandom_range(0, 60);
            for (int n = 0; n < PHASE_LEN; n++) begin
                pick = $urandom_range(0, 99);
                idx  = (pick < 60) ? bphd_pkg::IDX_W'(focus + $urandom_range(0, 3))
                                   : bphd_pkg::IDX_W'($urandom_range(0, 63));
                r = $urandom_range(0, 99);
                if (r < 45)
                    mag = '0;
                else if (r < 65)
                    mag = bphd_pkg::MAG_W'($urandom_range(0, 15));
                else if (r < 90)
                    mag = bphd_pkg::MAG_W'($urandom_range(0, 255));
                else
                    mag = 8'd255;
                send_word(idx, mag);
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        $display("summary: %0d words over %0d decay settings, %0d results compared",
                 words_sent, settings_used + 1, compared);
        if (mismatches == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
